>>> rtl/binary_heap_priority_queue_defines.svh
// Assertion macros shared by the heap queue RTL.
// Needs a clk and an active-low rst_n in the scope where a macro is used.
`ifndef BINARY_HEAP_PRIORITY_QUEUE_DEFINES_SVH
`define BINARY_HEAP_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define BHPQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define BHPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/bhpq_pkg.sv
// Heap queue package: operation and status codes.
// No dependencies.
package bhpq_pkg;

  localparam int MODE_W   = 2;
  localparam int STATUS_W = 2;

  typedef logic [MODE_W-1:0]   mode_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam mode_t MODE_PUSH = 2'd0;
  localparam mode_t MODE_POP  = 2'd1;
  localparam mode_t MODE_PEEK = 2'd2;

  localparam status_t STAT_OK    = 2'd0;
  localparam status_t STAT_FULL  = 2'd1;
  localparam status_t STAT_EMPTY = 2'd2;

endpackage

>>> rtl/bhpq_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bhpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/binary_heap_priority_queue.sv
// Binary heap priority queue top level: sequencer, shared comparator, heap RAM.
// Depends on bhpq_pkg, bhpq_ram and binary_heap_priority_queue_defines.svh.
//
//  channel  ports                                      handshake
//  -------  -----------------------------------------  ---------------------------
//  in       in_mode, in_item_value                     start && !busy
//  out      out_top_value, out_status, out_entry_count out_valid, one cycle
//  cfg      cfg_wdata (order_select)                   cfg_we, write when idle
//
// Push: reads each parent in turn and moves it down while the new entry precedes it, up to the root.
// Pop: reads the root and the last entry, then per node reads the children, picks one, compares, moves it up.
// Peek reads only the root; full or empty errors go straight to the result.
// Pace: one registered RAM read per step and one comparator shared by every sift step.
// rst_n clears the count and order; RAM contents stay undefined until written.
// out_valid cannot be stalled; busy is high from an accepted beat until its result.
`include "binary_heap_priority_queue_defines.svh"

module binary_heap_priority_queue #(
  parameter int CAPACITY    = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  bhpq_pkg::mode_t                   in_mode,
  input  logic [VALUE_WIDTH-1:0]            in_item_value,
  output logic                              out_valid,
  output logic [VALUE_WIDTH-1:0]            out_top_value,
  output bhpq_pkg::status_t                 out_status,
  output logic [$clog2(CAPACITY+1)-1:0]     out_entry_count,
  input  logic                              cfg_we,
  input  logic                              cfg_wdata
);

  import bhpq_pkg::*;

  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int ADDR_W = $clog2(CAPACITY);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_UP_RD   = 4'd1;
  localparam logic [3:0] S_UP_CMP  = 4'd2;
  localparam logic [3:0] S_RT_WAIT = 4'd3;
  localparam logic [3:0] S_LAST    = 4'd4;
  localparam logic [3:0] S_DN_RDL  = 4'd5;
  localparam logic [3:0] S_DN_RDR  = 4'd6;
  localparam logic [3:0] S_DN_PICK = 4'd7;
  localparam logic [3:0] S_DN_CMP  = 4'd8;
  localparam logic [3:0] S_DONE    = 4'd9;

  logic [3:0]             state_r, state_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [CNT_W-1:0]       pos_r, pos_nxt;
  logic [CNT_W-1:0]       cpos_r, cpos_nxt;
  logic [VALUE_WIDTH-1:0] val_r, val_nxt;
  logic [VALUE_WIDTH-1:0] cval_r, cval_nxt;
  logic [VALUE_WIDTH-1:0] top_r, top_nxt;
  status_t                status_r, status_nxt;
  logic                   is_pop_r, is_pop_nxt;
  logic                   order_r;

  logic                   out_valid_r;
  logic [VALUE_WIDTH-1:0] out_top_r;
  status_t                out_status_r;
  logic [CNT_W-1:0]       out_count_r;
  logic                   out_err;

  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_waddr, ram_raddr;
  logic [VALUE_WIDTH-1:0] ram_wdata, ram_rdata;

  logic [VALUE_WIDTH-1:0] cmp_a, cmp_b;
  logic                   prec;

  logic [CNT_W:0]         lpos, rpos, cnt_ext;
  logic [CNT_W:0]         lpos_m1;
  logic [CNT_W-1:0]       pos_m1, par, par_m1, cnt_m1;
  logic                   has_l, has_r, accept;

  bhpq_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (CAPACITY)
  ) u_heap_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign accept  = start && !busy;
  assign lpos    = {pos_r, 1'b0};
  assign rpos    = lpos + (CNT_W+1)'(1);
  assign lpos_m1 = lpos - (CNT_W+1)'(1);
  assign cnt_ext = {1'b0, cnt_r};
  assign has_l   = (lpos <= cnt_ext);
  assign has_r   = (lpos < cnt_ext);
  assign pos_m1  = pos_r - CNT_W'(1);
  assign par     = pos_r >> 1;
  assign par_m1  = par - CNT_W'(1);
  assign cnt_m1  = cnt_r - CNT_W'(1);

  // Shared comparator: "a strictly precedes b" under the current order
  always_comb begin
    case (state_r)
      S_DN_PICK: begin
        cmp_a = cval_r;
        cmp_b = ram_rdata;
      end
      S_DN_CMP: begin
        cmp_a = cval_r;
        cmp_b = val_r;
      end
      default: begin
        cmp_a = val_r;
        cmp_b = ram_rdata;
      end
    endcase
  end

  assign prec = order_r ? (cmp_a > cmp_b) : (cmp_a < cmp_b);

  // Sequencer. Sifts carry the moving entry in val_r and write it once at the
  // end; the displaced entries are written as the hole moves.
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    pos_nxt    = pos_r;
    cpos_nxt   = cpos_r;
    val_nxt    = val_r;
    cval_nxt   = cval_r;
    top_nxt    = top_r;
    status_nxt = status_r;
    is_pop_nxt = is_pop_r;
    ram_we     = 1'b0;
    ram_waddr  = pos_m1[ADDR_W-1:0];
    ram_wdata  = val_r;
    ram_raddr  = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          top_nxt    = '0;
          status_nxt = STAT_OK;
          is_pop_nxt = (in_mode == MODE_POP);
          state_nxt  = S_DONE;
          case (in_mode) inside
            MODE_PUSH: begin
              if (cnt_r == CNT_W'(CAPACITY)) begin
                status_nxt = STAT_FULL;
              end else begin
                cnt_nxt   = cnt_r + CNT_W'(1);
                pos_nxt   = cnt_r + CNT_W'(1);
                val_nxt   = in_item_value;
                state_nxt = S_UP_RD;
              end
            end
            MODE_POP, MODE_PEEK: begin
              if (cnt_r == '0) begin
                status_nxt = STAT_EMPTY;
              end else begin
                ram_raddr = '0;
                state_nxt = S_RT_WAIT;
              end
            end
            default: ;
          endcase
        end
      end
      S_UP_RD: begin
        if (pos_r == CNT_W'(1)) begin
          ram_we    = 1'b1;
          state_nxt = S_DONE;
        end else begin
          ram_raddr = par_m1[ADDR_W-1:0];
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        ram_we = 1'b1;
        if (prec) begin
          ram_wdata = ram_rdata;
          pos_nxt   = par;
          state_nxt = S_UP_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_RT_WAIT: begin
        top_nxt = ram_rdata;
        if (is_pop_r) begin
          ram_raddr = cnt_m1[ADDR_W-1:0];
          cnt_nxt   = cnt_m1;
          state_nxt = S_LAST;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_LAST: begin
        val_nxt = ram_rdata;
        pos_nxt = CNT_W'(1);
        // popping the only entry leaves nothing to sift
        state_nxt = (cnt_r == '0) ? S_DONE : S_DN_RDL;
      end
      S_DN_RDL: begin
        if (has_l) begin
          ram_raddr = lpos_m1[ADDR_W-1:0];
          state_nxt = S_DN_RDR;
        end else begin
          ram_we    = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_DN_RDR: begin
        cval_nxt = ram_rdata;
        cpos_nxt = lpos[CNT_W-1:0];
        if (has_r) begin
          ram_raddr = lpos[ADDR_W-1:0];
          state_nxt = S_DN_PICK;
        end else begin
          state_nxt = S_DN_CMP;
        end
      end
      S_DN_PICK: begin
        // ties go right
        if (!prec) begin
          cval_nxt = ram_rdata;
          cpos_nxt = rpos[CNT_W-1:0];
        end
        state_nxt = S_DN_CMP;
      end
      S_DN_CMP: begin
        ram_we = 1'b1;
        if (prec) begin
          ram_wdata = cval_r;
          pos_nxt   = cpos_r;
          state_nxt = S_DN_RDL;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      order_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= (state_r == S_DONE);
      if (cfg_we) begin
        order_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    cpos_r   <= cpos_nxt;
    val_r    <= val_nxt;
    cval_r   <= cval_nxt;
    top_r    <= top_nxt;
    status_r <= status_nxt;
    is_pop_r <= is_pop_nxt;
    if (state_r == S_DONE) begin
      out_top_r    <= top_r;
      out_status_r <= status_r;
      out_count_r  <= cnt_r;
    end
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_top_value   = out_top_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_count_r;
  assign out_err         = out_valid_r && (out_status_r != STAT_OK);

  `BHPQ_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(CAPACITY), "entry count over capacity")
  `BHPQ_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted beat did not raise busy")
  `BHPQ_ASSERT_NOW(a_strobe_idle, out_valid_r, state_r == S_IDLE, "result strobe while busy")
  `BHPQ_ASSERT_NOW(a_no_idle_write, ram_we, state_r != S_IDLE, "heap write while idle")
  `BHPQ_ASSERT_NOW(a_err_zero, out_err, out_top_r == '0, "error result carries a value")

endmodule

>>> bench/binary_heap_priority_queue_checker.sv
`timescale 1ns / 1ps
// Checker for the heap queue: mirrors the heap from accepted beats and compares each result.
// Depends on bhpq_pkg; bound beside the block by binary_heap_priority_queue_tb.
module binary_heap_priority_queue_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  bhpq_pkg::mode_t   in_mode,
  input  logic [31:0]       in_item_value,
  input  logic              out_valid,
  input  logic [31:0]       out_top_value,
  input  bhpq_pkg::status_t out_status,
  input  logic [10:0]       out_entry_count,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  output int                failures,
  output int                pending,
  output int                stored,
  output int                results_seen,
  output int                full_rejects,
  output int                empty_rejects
);

  import bhpq_pkg::*;

  localparam int DEPTH = 1024;

  typedef struct packed {
    logic [31:0] top;
    status_t     status;
    logic [10:0] count;
  } heap_result_t;

  logic [31:0]  slot [1:DEPTH];
  int           heap_fill;
  logic         keep_largest;
  heap_result_t result_q [$];

  function automatic logic ahead(logic [31:0] a, logic [31:0] b);
    return keep_largest ? (a > b) : (a < b);
  endfunction

  function automatic void swap_slots(int a, int b);
    logic [31:0] t;
    t       = slot[a];
    slot[a] = slot[b];
    slot[b] = t;
  endfunction

  function automatic void climb(int pos);
    while (pos > 1 && ahead(slot[pos], slot[pos / 2])) begin
      swap_slots(pos, pos / 2);
      pos = pos / 2;
    end
  endfunction

  // ties between the children go right
  function automatic void sink(int pos);
    int   l;
    int   r;
    int   pick;
    logic has_r;
    while (2 * pos <= heap_fill) begin
      l     = 2 * pos;
      r     = l + 1;
      has_r = (r <= heap_fill);
      if (!(ahead(slot[l], slot[pos]) || (has_r && ahead(slot[r], slot[pos]))))
        break;
      pick = (!has_r || ahead(slot[l], slot[r])) ? l : r;
      swap_slots(pos, pick);
      pos = pick;
    end
  endfunction

  function automatic heap_result_t apply_beat(mode_t m, logic [31:0] v);
    heap_result_t res;
    res = '0;
    res.status = STAT_OK;
    case (m) inside
      MODE_PUSH: begin
        if (heap_fill >= DEPTH) begin
          res.status = STAT_FULL;
          full_rejects++;
        end else begin
          heap_fill++;
          slot[heap_fill] = v;
          climb(heap_fill);
        end
      end
      MODE_POP, MODE_PEEK: begin
        if (heap_fill == 0) begin
          res.status = STAT_EMPTY;
          empty_rejects++;
        end else begin
          res.top = slot[1];
          if (m == MODE_POP) begin
            slot[1] = slot[heap_fill];
            heap_fill--;
            sink(1);
          end
        end
      end
      default: ; // unused code: no change
    endcase
    res.count = heap_fill[10:0];
    return res;
  endfunction

  always @(posedge clk) begin
    heap_result_t due;
    if (!rst_n) begin
      heap_fill    = 0;
      keep_largest = 1'b0;
      result_q.delete();
    end else begin
      // a result always belongs to an earlier beat than one taken at this edge
      if (out_valid) begin
        results_seen++;
        if (result_q.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("%0t: result with nothing outstanding: top=%h status=%0d count=%0d",
                     $realtime, out_top_value, out_status, out_entry_count);
        end else begin
          due = result_q.pop_front();
          if (out_top_value !== due.top || out_status !== due.status ||
              out_entry_count !== due.count) begin
            failures++;
            if (failures <= 10)
              $display("%0t: exp top=%h st=%0d cnt=%0d, got top=%h st=%0d cnt=%0d",
                       $realtime, due.top, due.status, due.count,
                       out_top_value, out_status, out_entry_count);
          end
        end
      end
      if (cfg_we)
        keep_largest = cfg_wdata;
      if (start && !busy)
        result_q.push_back(apply_beat(in_mode, in_item_value));
    end
    pending = result_q.size();
    stored  = heap_fill;
  end

endmodule

>>> bench/binary_heap_priority_queue_tb.sv
`timescale 1ns / 1ps
// Testbench top for the heap queue: clock, reset, directed and random beats, verdict.
// Depends on bhpq_pkg, binary_heap_priority_queue and binary_heap_priority_queue_checker.
module binary_heap_priority_queue_tb;
  import bhpq_pkg::*;

  localparam int    DEPTH      = 1024;
  localparam mode_t MODE_SPARE = 2'd3;

  logic        clk           = 1'b0;
  logic        rst_n         = 1'b0;
  logic        start         = 1'b0;
  logic        busy;
  mode_t       in_mode       = MODE_PUSH;
  logic [31:0] in_item_value = '0;
  logic        out_valid;
  logic [31:0] out_top_value;
  status_t     out_status;
  logic [10:0] out_entry_count;
  logic        cfg_we        = 1'b0;
  logic        cfg_wdata     = 1'b0;

  int failures;
  int pending;
  int stored;
  int results_seen;
  int full_rejects;
  int empty_rejects;

  int gap_pct = 0;
  int issued [4];

  always #4 clk = ~clk;

  binary_heap_priority_queue u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_mode         (in_mode),
    .in_item_value   (in_item_value),
    .out_valid       (out_valid),
    .out_top_value   (out_top_value),
    .out_status      (out_status),
    .out_entry_count (out_entry_count),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata)
  );

  binary_heap_priority_queue_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_mode         (in_mode),
    .in_item_value   (in_item_value),
    .out_valid       (out_valid),
    .out_top_value   (out_top_value),
    .out_status      (out_status),
    .out_entry_count (out_entry_count),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .failures        (failures),
    .pending         (pending),
    .stored          (stored),
    .results_seen    (results_seen),
    .full_rejects    (full_rejects),
    .empty_rejects   (empty_rejects)
  );

  // one beat; optional idle burst first, with junk on the payload meanwhile
  task automatic issue(input mode_t m, input logic [31:0] v);
    logic took;
    if ($urandom_range(1, 100) <= gap_pct) begin
      start         <= 1'b0;
      in_mode       <= mode_t'($urandom);
      in_item_value <= $urandom;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    start         <= 1'b1;
    in_mode       <= m;
    in_item_value <= v;
    issued[m]++;
    do begin
      @(negedge clk);
      took = !busy;
      @(posedge clk);
    end while (!took);
  endtask

  // order register only changes with nothing in flight
  task automatic set_order(input logic largest_first);
    start <= 1'b0;
    do @(negedge clk); while (pending != 0 || busy);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= largest_first;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic mode_t pick_mode(int w_push, int w_pop, int w_peek);
    int r;
    r = $urandom_range(0, 99);
    if (r < w_push)
      return MODE_PUSH;
    if (r < w_push + w_pop)
      return MODE_POP;
    if (r < w_push + w_pop + w_peek)
      return MODE_PEEK;
    return MODE_SPARE;
  endfunction

  // small values make plenty of ties
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9)) inside
      [0:2]:   return $urandom_range(0, 15);
      3:       return '0;
      4:       return '1;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int room;
    int waited;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: min-heap, empty errors, extremes, ties, full drain
    set_order(1'b0);
    issue(MODE_PEEK, 32'h0);
    issue(MODE_POP, 32'hFFFF_FFFF);
    issue(MODE_SPARE, 32'h1234_5678);
    issue(MODE_PUSH, 32'd5);
    issue(MODE_PUSH, 32'h0);
    issue(MODE_PUSH, 32'hFFFF_FFFF);
    issue(MODE_PUSH, 32'd5);
    issue(MODE_PUSH, 32'h0);
    issue(MODE_PUSH, 32'h8000_0000);
    issue(MODE_SPARE, 32'h0);
    issue(MODE_PEEK, 32'h0);
    repeat (6) issue(MODE_POP, 32'h0);
    issue(MODE_POP, 32'h0);

    // directed: max-heap
    set_order(1'b1);
    issue(MODE_PUSH, 32'd7);
    issue(MODE_PUSH, 32'd7);
    issue(MODE_PUSH, 32'h0);
    issue(MODE_PUSH, 32'hFFFF_FFFF);
    issue(MODE_PEEK, 32'h0);
    issue(MODE_POP, 32'h0);
    issue(MODE_POP, 32'h0);

    // mixed traffic, still largest first
    gap_pct = 30;
    repeat (220) issue(pick_mode(45, 35, 15), pick_value());

    // fill to capacity under the other order, then push past it
    set_order(1'b0);
    room    = DEPTH - stored;
    gap_pct = 10;
    repeat (room + 6) issue(MODE_PUSH, pick_value());
    issue(MODE_PEEK, 32'h0);

    // hover around full with the order flipped over a full heap
    set_order(1'b1);
    gap_pct = 40;
    repeat (120) issue(pick_mode(50, 40, 10), pick_value());

    // back to back, pop heavy
    gap_pct = 0;
    repeat (180) issue(pick_mode(30, 55, 10), pick_value());

    start  <= 1'b0;
    waited = 0;
    do begin
      @(negedge clk);
      waited++;
    end while (pending != 0 && waited < 2000);
    repeat (60) @(posedge clk);

    $display("Beats sent: %0d push, %0d pop, %0d peek, %0d unused code; %0d results checked",
             issued[MODE_PUSH], issued[MODE_POP], issued[MODE_PEEK], issued[MODE_SPARE],
             results_seen);
    $display("Both orderings run; %0d pushes refused on a full heap, %0d pops/peeks on empty",
             full_rejects, empty_rejects);
    if (failures == 0 && pending == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #6_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/bhpq_pkg.sv
rtl/bhpq_ram.sv
rtl/binary_heap_priority_queue.sv
bench/binary_heap_priority_queue_checker.sv
bench/binary_heap_priority_queue_tb.sv
